@@ rtl/bqff_pkg.sv @@
// ----------------------------------------------------------------------------
// Biquad feedforward filter package
// Shared types and constants: coefficient set, register indexes, item kinds.
// ----------------------------------------------------------------------------
package bqff_pkg;

   localparam int COEF_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

   // Item kind carried on req_tuser
   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_CLEAR  = 1'b1
   } kind_type;

   // Normalized coefficients, signed, COEF_FRAC_BITS fraction bits
   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
   } coef_set_type;

   // Control of one pipeline stage handed to the next
   typedef struct packed {
      logic valid;
      logic clear;
   } stage_ctl_type;

endpackage

@@ rtl/bqff_regs.sv @@
// ----------------------------------------------------------------------------
// Biquad coefficient registers
// Five write-only coefficient registers; b0 resets to unity gain.
// ----------------------------------------------------------------------------
module bqff_regs #(
   parameter int COEF_FRAC_BITS = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_wr_en,
   input  logic [bqff_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [bqff_pkg::COEF_WIDTH-1:0]           csr_wdata,
   output bqff_pkg::coef_set_type                    coef
);
   import bqff_pkg::*;

   localparam logic [COEF_WIDTH-1:0] B0_RESET =
      {{(COEF_WIDTH-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

   coef_set_type coef_ff;
   coef_set_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_B0:  coef_in.b0 = csr_wdata;
            CSR_B1:  coef_in.b1 = csr_wdata;
            CSR_B2:  coef_in.b2 = csr_wdata;
            CSR_A1:  coef_in.a1 = csr_wdata;
            CSR_A2:  coef_in.a2 = csr_wdata;
            default: coef_in = coef_ff;   // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= B0_RESET;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

@@ rtl/bqff_fwd.sv @@
// ----------------------------------------------------------------------------
// Biquad feedforward path
// Input history, numerator products and their sum over three stages.
// ----------------------------------------------------------------------------
module bqff_fwd #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic                                           in_clear,
   input  logic signed [SAMPLE_WIDTH-1:0]                 in_sample,
   input  bqff_pkg::coef_set_type                         coef,
   output bqff_pkg::stage_ctl_type                        out_ctl,
   input  logic                                           out_ready,
   output logic signed [SAMPLE_WIDTH+bqff_pkg::COEF_WIDTH+1:0] out_sum
);
   import bqff_pkg::*;

   localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;   // exact product width
   localparam int FW = PW + 2;                      // sum of three products

   // input history
   logic signed [SAMPLE_WIDTH-1:0] xprev1_ff, xprev1_in, xprev2_ff, xprev2_in;

   // stage A: current and past samples
   stage_ctl_type                  a_ctl_ff, a_ctl_in;
   logic signed [SAMPLE_WIDTH-1:0] a_x0_ff, a_x0_in, a_x1_ff, a_x1_in, a_x2_ff, a_x2_in;

   // stage B: products
   stage_ctl_type        b_ctl_ff, b_ctl_in;
   logic signed [PW-1:0] b_p0_ff, b_p0_in, b_p1_ff, b_p1_in, b_p2_ff, b_p2_in;

   // stage C: feedforward sum
   stage_ctl_type        c_ctl_ff, c_ctl_in;
   logic signed [FW-1:0] c_sum_ff, c_sum_in;

   logic ready_a, ready_b, ready_c, take;
   logic signed [COEF_WIDTH-1:0] cb0, cb1, cb2;

   assign cb0 = coef.b0;
   assign cb1 = coef.b1;
   assign cb2 = coef.b2;

   // a stage loads when empty or when its content moves on
   assign ready_c  = !c_ctl_ff.valid || out_ready;
   assign ready_b  = !b_ctl_ff.valid || ready_c;
   assign ready_a  = !a_ctl_ff.valid || ready_b;
   assign in_ready = ready_a;
   assign take     = in_valid && ready_a;

   always_comb begin
      xprev1_in = xprev1_ff;
      xprev2_in = xprev2_ff;
      a_ctl_in  = a_ctl_ff;
      a_x0_in   = a_x0_ff;
      a_x1_in   = a_x1_ff;
      a_x2_in   = a_x2_ff;
      if (ready_a) begin
         a_ctl_in.valid = in_valid;
         a_ctl_in.clear = in_clear;
      end
      if (take) begin
         a_x0_in = in_sample;
         a_x1_in = xprev1_ff;
         a_x2_in = xprev2_ff;
         if (in_clear) begin
            xprev1_in = '0;
            xprev2_in = '0;
         end else begin
            xprev1_in = in_sample;
            xprev2_in = xprev1_ff;
         end
      end
   end

   always_comb begin
      b_ctl_in = b_ctl_ff;
      b_p0_in  = b_p0_ff;
      b_p1_in  = b_p1_ff;
      b_p2_in  = b_p2_ff;
      if (ready_b) begin
         b_ctl_in = a_ctl_ff;
         b_p0_in  = a_x0_ff * cb0;
         b_p1_in  = a_x1_ff * cb1;
         b_p2_in  = a_x2_ff * cb2;
      end
   end

   always_comb begin
      c_ctl_in = c_ctl_ff;
      c_sum_in = c_sum_ff;
      if (ready_c) begin
         c_ctl_in = b_ctl_ff;
         c_sum_in = FW'(b_p0_ff) + FW'(b_p1_ff) + FW'(b_p2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xprev1_ff <= '0;
         xprev2_ff <= '0;
         a_ctl_ff  <= '0;
         b_ctl_ff  <= '0;
         c_ctl_ff  <= '0;
      end else begin
         xprev1_ff <= xprev1_in;
         xprev2_ff <= xprev2_in;
         a_ctl_ff  <= a_ctl_in;
         b_ctl_ff  <= b_ctl_in;
         c_ctl_ff  <= c_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      a_x0_ff  <= a_x0_in;
      a_x1_ff  <= a_x1_in;
      a_x2_ff  <= a_x2_in;
      b_p0_ff  <= b_p0_in;
      b_p1_ff  <= b_p1_in;
      b_p2_ff  <= b_p2_in;
      c_sum_ff <= c_sum_in;
   end

   assign out_ctl = c_ctl_ff;
   assign out_sum = c_sum_ff;

endmodule

@@ rtl/bqff_loop.sv @@
// ----------------------------------------------------------------------------
// Biquad feedback stage
// Subtract the output-history terms, round, saturate and hold the result.
// ----------------------------------------------------------------------------
module bqff_loop #(
   parameter int SAMPLE_WIDTH   = 32,
   parameter int COEF_FRAC_BITS = 24
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  bqff_pkg::stage_ctl_type                             in_ctl,
   output logic                                                in_ready,
   input  logic signed [SAMPLE_WIDTH+bqff_pkg::COEF_WIDTH+1:0] in_sum,
   input  bqff_pkg::coef_set_type                              coef,
   output logic                                                out_valid,
   input  logic                                                out_ready,
   output logic signed [SAMPLE_WIDTH-1:0]                      out_drive
);
   import bqff_pkg::*;

   localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int AW = PW + 3;   // five exact terms

   localparam logic signed [AW-1:0] HALF =
      {{(AW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic signed [AW-1:0] SAT_MAX =
      {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [AW-1:0] SAT_MIN =
      {{(AW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [SAMPLE_WIDTH-1:0] yprev1_ff, yprev1_in, yprev2_ff, yprev2_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_drive_ff, rsp_drive_in;

   logic signed [COEF_WIDTH-1:0]   ca1, ca2;
   logic signed [PW-1:0]           pa1, pa2;
   logic signed [AW-1:0]           acc, rounded;
   logic signed [SAMPLE_WIDTH-1:0] y;
   logic                           load;

   assign ca1 = coef.a1;
   assign ca2 = coef.a2;
   assign pa1 = yprev1_ff * ca1;
   assign pa2 = yprev2_ff * ca2;

   assign acc     = AW'(in_sum) - AW'(pa1) - AW'(pa2);
   assign rounded = (acc + HALF) >>> COEF_FRAC_BITS;

   always_comb begin
      if (rounded > SAT_MAX) begin
         y = SAT_MAX[SAMPLE_WIDTH-1:0];
      end else if (rounded < SAT_MIN) begin
         y = SAT_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         y = rounded[SAMPLE_WIDTH-1:0];
      end
   end

   assign in_ready = !rsp_valid_ff || out_ready;
   assign load     = in_ctl.valid && in_ready;

   always_comb begin
      yprev1_in    = yprev1_ff;
      yprev2_in    = yprev2_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      if (load) begin
         if (in_ctl.clear) begin
            yprev1_in = '0;
            yprev2_in = '0;
         end else begin
            yprev1_in    = y;
            yprev2_in    = yprev1_ff;
            rsp_drive_in = y;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yprev1_ff    <= '0;
         yprev2_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         yprev1_ff    <= yprev1_in;
         yprev2_ff    <= yprev2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_drive_ff <= rsp_drive_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_drive = rsp_drive_ff;

endmodule

@@ rtl/biquad_feedforward_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Biquad feedforward filter unit
// Second-order direct form I filter for a speed reference feedforward.
// ----------------------------------------------------------------------------
// Usage:
//   Feed reference samples on the req_ stream; req_tuser selects a filter
//   sample (KIND_SAMPLE) or a history clear (KIND_CLEAR). Each sample gives
//   one transfer on the rsp_ stream:
//      drive = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
//   rounded half up to the sample format and saturated. A clear zeroes all
//   four history registers in stream order and gives no transfer.
//   Coefficients are written through csr_ while the unit is idle.
// Path and throughput:
//   An accepted sample passes stages A, B and C and then the result
//   register; one item per cycle is sustained while rsp_tready is high,
//   as the feedback stage closes a1*y1, a2*y2, rounding and saturation.
// Reset:
//   Synchronous; empties the pipeline, zeroes the history, sets b0 to 1.0
//   and the other coefficients to zero. No clearing pass is needed.
// Stall:
//   The result register holds while rsp_tready is low; bubbles in the
//   three-stage pipe ahead of it still fill, so req_tready drops only
//   once every stage is occupied.
// ----------------------------------------------------------------------------
module biquad_feedforward_filter_unit #(
   parameter int SAMPLE_WIDTH   = 32,
   parameter int COEF_FRAC_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      req_tdata,   // [SAMPLE_WIDTH-1:0] reference
   input  logic [0:0]                             req_tuser,   // [0] kind
   // result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,   // [SAMPLE_WIDTH-1:0] drive
   // coefficient registers
   input  logic                                   csr_wr_en,
   input  logic [bqff_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bqff_pkg::COEF_WIDTH-1:0]        csr_wdata
);
   import bqff_pkg::*;

   localparam int TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int FW          = SAMPLE_WIDTH + COEF_WIDTH + 2;

   coef_set_type                   coef;
   stage_ctl_type                  fwd_ctl;
   logic                           loop_ready;
   logic signed [FW-1:0]           fwd_sum;
   logic signed [SAMPLE_WIDTH-1:0] reference;
   logic signed [SAMPLE_WIDTH-1:0] drive;
   logic                           is_clear;

   // unpack the input transfer; padding bits above the sample are unused
   assign reference = req_tdata[SAMPLE_WIDTH-1:0];
   assign is_clear  = (req_tuser[0] == KIND_CLEAR);

   bqff_regs #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   // input history, numerator products, feedforward sum
   bqff_fwd #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_clear  (is_clear),
      .in_sample (reference),
      .coef      (coef),
      .out_ctl   (fwd_ctl),
      .out_ready (loop_ready),
      .out_sum   (fwd_sum)
   );

   // output history, round, saturate, result register
   bqff_loop #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_loop (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (fwd_ctl),
      .in_ready  (loop_ready),
      .in_sum    (fwd_sum),
      .coef      (coef),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_drive (drive)
   );

   // zero-fill the result up to whole bytes
   assign rsp_tdata = TDATA_WIDTH'($unsigned(drive));

endmodule
